// ===== rtl/bba_pkg.sv =====
// shared types, constants and helper functions of the bitmap block allocator
package bba_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = 3;
  localparam int COUNT_W       = 13;
  localparam int FFB_W         = 12;

  // request opcodes
  localparam logic [1:0] OP_PROBE   = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COUNT_W-1:0] block_count;
  } bba_in_t;

  typedef struct packed {
    logic             success;
    logic [FFB_W-1:0] first_free_block;
    logic             first_free_valid;
  } bba_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } bba_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sweep;
    logic scan_rd;
    logic publish;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic scan_last;
  } bba_stat_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      cnt = cnt + 4'(v[k]);
    end
    return cnt;
  endfunction

  // lowest n set bits of v
  function automatic logic [7:0] lowest_n(input logic [7:0] v, input logic [3:0] n);
    logic [7:0] sel;
    logic [3:0] cnt;
    sel = '0;
    cnt = '0;
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      if (v[k] && (cnt < n)) begin
        sel[k] = 1'b1;
        cnt    = cnt + 4'd1;
      end
    end
    return sel;
  endfunction

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_IDX_W-1:0] lowest_idx(input logic [7:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int k = BITS_PER_BYTE - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = BIT_IDX_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bba_ram.sv =====
// generic simple dual-port ram with registered read
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_ctrl.sv =====
// request sequencer of the bitmap block allocator
module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bba_pkg::bba_stat_t stat_i,
  output bba_pkg::bba_cmd_t  cmd_o
);
  import bba_pkg::*;

  bba_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_opcode_i == OP_CLEAR) ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");
`endif

endmodule

// ===== rtl/bba_datapath.sv =====
// bitmap memory, scan counters and result registers of the allocator
module bba_datapath #(
  parameter int NUM_BLOCKS   = 4096,
  parameter int BITMAP_BYTES = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bba_pkg::bba_cmd_t  cmd_i,
  output bba_pkg::bba_stat_t stat_o,
  input  bba_pkg::bba_in_t   in_data_i,
  output bba_pkg::bba_out_t  out_data_o
);
  import bba_pkg::*;

  localparam int MAP_BITS    = BITMAP_BYTES * BITS_PER_BYTE;
  localparam int SCAN_BLOCKS = (NUM_BLOCKS < MAP_BITS) ? NUM_BLOCKS : MAP_BITS;
  localparam int SCAN_BYTES  = (SCAN_BLOCKS + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
  localparam int LAST_BITS   = SCAN_BLOCKS - BITS_PER_BYTE * (SCAN_BYTES - 1);
  localparam int AW          = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int BW          = AW + BIT_IDX_W;

  localparam logic [7:0]    LAST_MASK = 8'((1 << LAST_BITS) - 1);
  localparam logic [AW-1:0] SWEEP_END = AW'(BITMAP_BYTES - 1);
  localparam logic [AW-1:0] SCAN_END  = AW'(SCAN_BYTES - 1);

  logic [AW-1:0]      addr_q, addr_d;
  logic               proc_valid_q;
  logic [AW-1:0]      proc_addr_q;
  logic [1:0]         op_q;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic               ff_found_q, ff_found_d;
  logic [BW-1:0]      ff_blk_q, ff_blk_d;
  bba_out_t           out_q;

  logic [7:0]         rd_data;
  logic [7:0]         valid_mask;
  logic [7:0]         free_mask;
  logic [3:0]         free_cnt;
  logic [3:0]         take;
  logic [7:0]         set_mask;
  logic [7:0]         left_free;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic               success;

  bba_ram #(
    .WIDTH (BITS_PER_BYTE),
    .DEPTH (BITMAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // byte being modified this cycle
  always_comb begin
    valid_mask = (proc_addr_q == SCAN_END) ? LAST_MASK : 8'hFF;
    free_mask  = ~rd_data & valid_mask;
    free_cnt   = popcount8(free_mask);
    take       = (rem_q < COUNT_W'(free_cnt)) ? rem_q[3:0] : free_cnt;
    set_mask   = (op_q == OP_RESERVE) ? lowest_n(free_mask, take) : 8'h00;
    left_free  = free_mask & ~set_mask;
  end

  assign ram_we    = cmd_i.sweep || (proc_valid_q && (op_q == OP_RESERVE));
  assign ram_waddr = cmd_i.sweep ? addr_q : proc_addr_q;
  assign ram_wdata = cmd_i.sweep ? 8'h00 : (rd_data | set_mask);

  assign stat_o.sweep_last = (addr_q == SWEEP_END);
  assign stat_o.scan_last  = (addr_q == SCAN_END);

  always_comb begin
    addr_d     = addr_q;
    rem_d      = rem_q;
    ff_found_d = ff_found_q;
    ff_blk_d   = ff_blk_q;
    if (cmd_i.load) begin
      addr_d     = '0;
      rem_d      = in_data_i.block_count;
      ff_found_d = (in_data_i.opcode == OP_CLEAR);
      ff_blk_d   = '0;
    end else begin
      if (cmd_i.sweep || cmd_i.scan_rd) begin
        addr_d = AW'(addr_q + 1'b1);
      end
      if (proc_valid_q) begin
        rem_d = rem_q - COUNT_W'(take);
        if (!ff_found_q && (left_free != 8'h00)) begin
          ff_found_d = 1'b1;
          ff_blk_d   = {proc_addr_q, lowest_idx(left_free)};
        end
      end
    end
  end

  always_comb begin
    case (op_q)
      OP_PROBE:   success = (rem_q == '0);
      OP_RESERVE: success = (rem_q == '0);
      OP_CLEAR:   success = 1'b1;
      default:    success = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      proc_valid_q <= 1'b0;
      ff_found_q   <= 1'b0;
    end else begin
      addr_q       <= addr_d;
      proc_valid_q <= cmd_i.scan_rd;
      ff_found_q   <= ff_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_addr_q <= addr_q;
    rem_q       <= rem_d;
    ff_blk_q    <= ff_blk_d;
    if (cmd_i.load) begin
      op_q <= in_data_i.opcode;
    end
    if (cmd_i.publish) begin
      out_q.success          <= success;
      out_q.first_free_block <= ff_found_q ? FFB_W'(ff_blk_q) : '0;
      out_q.first_free_valid <= ff_found_q;
    end
  end

  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  // only free blocks ever get marked
  a_mark_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_valid_q |-> ((set_mask & ~free_mask) == 8'h00))
    else $error("reserve marks a block that was not free");

  // outstanding count never grows during a scan
  a_rem_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_valid_q && !cmd_i.load |=> (rem_q <= $past(rem_q)))
    else $error("outstanding block count increased");

  // first free block is frozen once found
  a_first_free_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ff_found_q && !cmd_i.load |=> ff_found_q && $stable(ff_blk_q))
    else $error("first free block changed after being found");
`endif

endmodule

// ===== rtl/bitmap_block_allocator_top.sv =====
// top level of the first-fit bitmap block allocator
//
// first-fit block allocator over a used-block bitmap held in a single
// BITMAP_BYTES x 8 ram, bit k of byte i standing for block i*8+k. one
// request (probe, reserve or clear) is taken at a time and gives exactly
// one result: success plus the lowest free block left afterwards.
// after reset the ram is swept to zero, during which no request is taken.
// a probe or reserve walks the first min(NUM_BLOCKS, BITMAP_BYTES*8)/8
// bytes, rounded up, one byte per cycle through the ram's single read
// port, with the write-back of a reserve in the cycle after the read.
// a clear sweeps the whole ram. a finished result sits in an output
// register; the next request is taken while it waits
module bitmap_block_allocator_top #(
  parameter int NUM_BLOCKS   = 4096,
  parameter int BITMAP_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bba_pkg::bba_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bba_pkg::bba_out_t out_data_o
);
  import bba_pkg::*;

  // command and status between sequencer and datapath
  bba_cmd_t  cmd;
  bba_stat_t stat;

  // sequencer: reset and clear sweeps, request accept, scan and result hand-off
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_opcode_i (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: bitmap ram, byte-wise read-modify-write, result registers
  bba_datapath #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== verif/bba_result_checker.sv =====
// result checker for the bitmap block allocator: predicts each response and compares it
`timescale 1ns / 100ps

module bba_result_checker #(
  parameter int NUM_BLOCKS   = 4096,
  parameter int BITMAP_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bba_pkg::bba_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bba_pkg::bba_out_t out_data_i,
  output int                pending_o,
  output int                errors_o
);
  import bba_pkg::*;

  // blocks beyond either limit are never free and never marked
  localparam int MANAGED = (NUM_BLOCKS < BITMAP_BYTES * BITS_PER_BYTE) ?
                           NUM_BLOCKS : BITMAP_BYTES * BITS_PER_BYTE;

  bit [MANAGED-1:0] block_taken;
  bba_out_t         expected_results[$];
  int               mismatches = 0;

  // applies one request to the shadow bitmap and returns the response it should give
  function automatic bba_out_t apply_request(input bba_in_t req);
    bba_out_t res;
    int       need;
    int       free_seen;
    res       = '0;
    need      = int'(req.block_count);
    free_seen = 0;
    case (req.opcode)
      OP_PROBE: begin
        for (int b = 0; b < MANAGED; b++) begin
          if (!block_taken[b]) free_seen++;
        end
        res.success = (free_seen >= need);
      end
      OP_RESERVE: begin
        // first fit, and a short reserve still takes what it finds
        for (int b = 0; b < MANAGED && need > 0; b++) begin
          if (!block_taken[b]) begin
            block_taken[b] = 1'b1;
            need--;
          end
        end
        res.success = (need == 0);
      end
      OP_CLEAR: begin
        block_taken = '0;
        res.success = 1'b1;
      end
      default: begin
        res.success = 1'b0;
      end
    endcase
    for (int b = MANAGED - 1; b >= 0; b--) begin
      if (!block_taken[b]) begin
        res.first_free_block = FFB_W'(b);
        res.first_free_valid = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bba_out_t want;
    if (!rst_ni) begin
      block_taken = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // response side first, so a request taken at this edge cannot answer itself
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing pending, expected none actual %0b/%0d/%0b",
                   $time, out_data_i.success, out_data_i.first_free_block,
                   out_data_i.first_free_valid);
        end else begin
          want = expected_results.pop_front();
          check_field("success", want.success, out_data_i.success);
          check_field("first_free_block", want.first_free_block,
                      out_data_i.first_free_block);
          check_field("first_free_valid", want.first_free_valid,
                      out_data_i.first_free_valid);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_request(in_data_i));
      end
      pending_o <= expected_results.size();
    end
  end

  assign errors_o = mismatches;

endmodule

// ===== verif/bitmap_block_allocator_top_test.sv =====
// testbench top for the bitmap block allocator: request stimulus, flow control and verdict
`timescale 1ns / 100ps

module bitmap_block_allocator_top_test;
  import bba_pkg::*;

  localparam int NUM_BLOCKS   = 4096;
  localparam int BITMAP_BYTES = 512;
  // opcode with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQS   = 450;
  // final stretch of the random part with no idling at all
  localparam int QUIET_TAIL    = 60;
  // allows several times the slowest run
  localparam int CYCLE_LIMIT   = 1_500_000;
  // longest request latency plus margin, for stray responses after the last one
  localparam int DRAIN_CYCLES  = 600;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bba_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b1;
  bba_out_t rsp;

  int pending;
  int errors;

  // stimulus bookkeeping
  logic idle_en      = 1'b1;
  int   blocks_taken = 0;
  int   n_probe      = 0;
  int   n_reserve    = 0;
  int   n_clear      = 0;
  int   n_unused     = 0;
  int   stall_left   = 0;
  int   cycle_count  = 0;

  always #4 clk = ~clk;

  bitmap_block_allocator_top #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BITMAP_BYTES(BITMAP_BYTES)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_data_i  (req),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_data_o (rsp)
  );

  bba_result_checker #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BITMAP_BYTES(BITMAP_BYTES)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_i (req_ready),
    .in_data_i  (req),
    .out_valid_i(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_data_i (rsp),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // response back-pressure: ready drops for bursts of random length, started at
  // random cycles so the stalls land on every phase of a scan
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 29) == 0) begin
      stall_left <= $urandom_range(1, 11);
      rsp_ready  <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // presents one request and returns at the edge where its transfer happens;
  // valid is left high so a back-to-back request follows without a gap
  task automatic send_req(input logic [1:0] op, input logic [COUNT_W-1:0] cnt);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, block_count: cnt};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    // rough fill level, only used to aim counts at the full-bitmap edge
    case (op)
      OP_PROBE: n_probe++;
      OP_RESERVE: begin
        n_reserve++;
        blocks_taken = blocks_taken + int'(cnt);
        if (blocks_taken > NUM_BLOCKS) blocks_taken = NUM_BLOCKS;
      end
      OP_CLEAR: begin
        n_clear++;
        blocks_taken = 0;
      end
      default: n_unused++;
    endcase
  endtask

  // block count for probes and reserves: mostly small, some aimed right at the
  // number of free blocks left, a few over the whole 13-bit range
  function automatic logic [COUNT_W-1:0] pick_count(input int left);
    int c;
    case ($urandom_range(0, 9))
      0:          c = 0;
      1, 2, 3, 4: c = $urandom_range(1, 400);
      5:          c = $urandom_range(1, 16);
      6, 7:       c = left + int'($urandom_range(0, 2)) - 1;
      8:          c = $urandom_range(1000, NUM_BLOCKS);
      default:    c = $urandom_range(0, 8191);
    endcase
    if (c < 0) c = 0;
    return COUNT_W'(c);
  endfunction

  initial begin : stimulus
    int pick;
    int left;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its bitmap after reset and holds ready low meanwhile
    @(posedge clk);

    // directed: zero counts, the all-free and full-bitmap edges, the unused opcode
    send_req(OP_PROBE, 0);
    send_req(OP_RESERVE, 0);
    send_req(OP_PROBE, 4096);
    send_req(OP_PROBE, 4097);
    send_req(OP_PROBE, 8191);
    send_req(OP_RESERVE, 1);
    send_req(OP_UNUSED, 8191);
    send_req(OP_UNUSED, 0);
    // takes exactly the last free blocks, leaving nothing free
    send_req(OP_RESERVE, 4095);
    send_req(OP_PROBE, 1);
    send_req(OP_PROBE, 0);
    send_req(OP_RESERVE, 0);
    send_req(OP_RESERVE, 1);
    send_req(OP_CLEAR, 0);
    send_req(OP_RESERVE, 4096);
    send_req(OP_CLEAR, 8191);
    send_req(OP_RESERVE, 100);
    send_req(OP_PROBE, 3996);
    send_req(OP_PROBE, 3997);
    // too few free: everything left gets marked, reported as a failure
    send_req(OP_RESERVE, 5000);
    send_req(OP_CLEAR, 4096);
    send_req(OP_RESERVE, 8191);
    send_req(OP_CLEAR, 0);
    // byte boundary
    send_req(OP_RESERVE, 7);
    send_req(OP_RESERVE, 1);

    // random: fill-up runs of reserves and probes, broken by clears and noise
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 30 == 0) begin
        idle_en <= (n < RANDOM_REQS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      end
      left = NUM_BLOCKS - blocks_taken;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_req(OP_CLEAR, COUNT_W'($urandom));
      end else if (pick < 9) begin
        send_req(OP_UNUSED, COUNT_W'($urandom));
      end else if (pick < 55) begin
        send_req(OP_RESERVE, pick_count(left));
      end else begin
        send_req(OP_PROBE, pick_count(left));
      end
    end
    req_valid <= 1'b0;

    // let the last transfer reach the checker, then wait for the responses
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d probes, %0d reserves, %0d clears, %0d unused opcode",
             n_probe + n_reserve + n_clear + n_unused, n_probe, n_reserve, n_clear, n_unused);
    $display("bursty idling on both channels, none in the final %0d requests", QUIET_TAIL);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
